// File: rtl/bmf_pkg.sv
// Shared constants, types and helper function of the 3x3 box mean filter.
package bmf_pkg;

   // Pixel and channel geometry
   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;
   localparam int PIX_W   = CH_W * NUM_CH;
   localparam int WIN_N   = 9;
   localparam int COORD_W = 11;

   // Configuration port
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   // Frame limits and reset geometry
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int MIN_DIM       = 3;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;

   // Window sum and divide by nine through a reciprocal
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

   typedef logic [PIX_W-1:0] pix_type;
   // Window entry index is row*3 + col, column 2 newest, row 2 current line
   typedef logic [WIN_N-1:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               frame_end;
   } meta_type;

   // floor(sum / 9) for sums below 2304; reciprocal error stays under one ninth
   function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] sum);
      logic [SUM_W+RECIP_W-1:0] prod;
      prod = SUM_W'(sum) * RECIP9;
      return prod[RECIP_SHIFT +: CH_W];
   endfunction

endpackage

// File: rtl/bmf_if.sv
// Channel interfaces of the box mean filter: pixel requests, results, register writes.
interface bmf_pix_if import bmf_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] chan0;
   logic [CH_W-1:0] chan1;
   logic [CH_W-1:0] chan2;

   modport source (output valid, chan0, chan1, chan2, input ready);
   modport sink   (input valid, chan0, chan1, chan2, output ready);
endinterface

interface bmf_rsp_if import bmf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CH_W-1:0]    mean0;
   logic [CH_W-1:0]    mean1;
   logic [CH_W-1:0]    mean2;
   logic [COORD_W-1:0] centre_row;
   logic [COORD_W-1:0] centre_col;
   logic               frame_end;

   modport source (output valid, mean0, mean1, mean2, centre_row, centre_col, frame_end,
                   input ready);
   modport sink   (input valid, mean0, mean1, mean2, centre_row, centre_col, frame_end,
                   output ready);
endinterface

interface bmf_csr_if import bmf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/box_mean_filter_3x3_rgb.sv
// 3x3 box mean filter over RGB pixels in raster order, with a line store of two lines.
// Registers on the path: request, window, sum, output. Throughput: one pixel per cycle when
// rsp does not stall; the line store memory does one read and one write a cycle.
// Border pixels give no result; each interior pixel gives one, tagged with the window centre.
// Reset clears position counters and pipeline valids and sets width 640 (at most MAX_WIDTH), height 480.
// The line store is not cleared; every entry is written in a frame before it is used.
module box_mean_filter_3x3_rgb import bmf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bmf_pix_if.sink    req,
   bmf_rsp_if.source  rsp,
   bmf_csr_if.sink    csr
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int CMPW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   // Geometry and position
   logic [CW-1:0]   last_col_ff, last_col_in;
   logic [RW-1:0]   last_row_ff, last_row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CMPW-1:0] w_ext;
   logic [CFG_W-1:0] h_val;
   logic            csr_wr;

   // Request stage waiting on the line store read
   logic            accept;
   logic            p1_valid_ff, p1_valid_in;
   pix_type         p1_pix_ff;
   logic [CW-1:0]   p1_col_ff;
   logic            p1_emit_ff;
   meta_type        p1_meta_ff;
   meta_type        meta_in;

   // Window stage
   logic            fire1;
   logic            adv1;
   logic            win_valid_ff, win_valid_in;
   win_type         win_ff;
   meta_type        win_meta_ff;
   logic            win_ready;
   logic [2*PIX_W-1:0] ls_rd_data;

   // Register writes: saturate the geometry once, keep the last column and row
   assign csr.ready = 1'b1;
   assign csr_wr    = csr.valid && csr.ready;
   assign w_ext     = CMPW'(csr.data);
   assign h_val     = csr.data;

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_wr) begin
         case (csr.index)
            REG_IMAGE_WIDTH: begin
               if (w_ext < CMPW'(MIN_DIM)) begin
                  last_col_in = CW'(MIN_DIM - 1);
               end else if (w_ext > CMPW'(MAX_WIDTH)) begin
                  last_col_in = CW'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = CW'(w_ext - CMPW'(1));
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (h_val < CFG_W'(MIN_DIM)) begin
                  last_row_in = RW'(MIN_DIM - 1);
               end else if (h_val > CFG_W'(MAX_HEIGHT)) begin
                  last_row_in = RW'(MAX_HEIGHT - 1);
               end else begin
                  last_row_in = RW'(h_val - CFG_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake chain: window stage frees when empty or handing off to the sum stage
   assign adv1      = !win_valid_ff || win_ready;
   assign fire1     = p1_valid_ff && adv1;
   assign req.ready = !p1_valid_ff || adv1;
   assign accept    = req.valid && req.ready;

   assign p1_valid_in  = accept ? 1'b1 : (fire1 ? 1'b0 : p1_valid_ff);
   assign win_valid_in = fire1 ? p1_emit_ff : (win_ready ? 1'b0 : win_valid_ff);

   // Raster position of the next pixel; a geometry write restarts the frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr && (csr.index == REG_IMAGE_WIDTH || csr.index == REG_IMAGE_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign meta_in.row       = COORD_W'(row_ff - RW'(1));
   assign meta_in.col       = COORD_W'(col_ff - CW'(1));
   assign meta_in.frame_end = (row_ff == last_row_ff) && (col_ff == last_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff  <= CW'(RST_W - 1);
         last_row_ff  <= RW'(HEIGHT_RESET - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         p1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         p1_valid_ff  <= p1_valid_in;
         win_valid_ff <= win_valid_in;
      end
   end

   // Request payload, held until the window stage takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_pix_ff  <= {req.chan2, req.chan1, req.chan0};
         p1_col_ff  <= col_ff;
         p1_emit_ff <= (row_ff >= RW'(2)) && (col_ff >= CW'(2));
         p1_meta_ff <= meta_in;
      end
   end

   // Window shift: new right column is upper, middle, current pixel
   always_ff @(posedge clock) begin
      if (fire1) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3 + 1];
            win_ff[r*3 + 1] <= win_ff[r*3 + 2];
         end
         win_ff[2]   <= ls_rd_data[PIX_W +: PIX_W];
         win_ff[5]   <= ls_rd_data[0 +: PIX_W];
         win_ff[8]   <= p1_pix_ff;
         win_meta_ff <= p1_meta_ff;
      end
   end

   // Read at request, write back one stage later; the next request reads another
   // column, and a request waits while the previous write-back is held
   bmf_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ls_rd_data),
      .wr_en   (fire1),
      .wr_addr (p1_col_ff),
      .wr_data ({ls_rd_data[0 +: PIX_W], p1_pix_ff})
   );

   bmf_mean_pipe u_mean_pipe (
      .clock     (clock),
      .reset     (reset),
      .win_valid (win_valid_ff),
      .win_ready (win_ready),
      .win       (win_ff),
      .win_meta  (win_meta_ff),
      .rsp       (rsp)
   );

endmodule

// File: rtl/bmf_line_store.sv
// Line store memory: per column, the pixel two rows up and one row up.
module bmf_line_store import bmf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output logic [2*PIX_W-1:0]            rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [2*PIX_W-1:0]            wr_data
);

   // Entry layout: upper line in the high half, middle line in the low half
   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while no new request is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bmf_mean_pipe.sv
// Window sum stage and divide by nine into the output register of the box mean filter.
module bmf_mean_pipe import bmf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         win_valid,
   output logic         win_ready,
   input  win_type      win,
   input  meta_type     win_meta,
   bmf_rsp_if.source    rsp
);

   logic                        s_valid_ff, s_valid_in;
   logic [NUM_CH-1:0][SUM_W-1:0] s_sum_ff, s_sum_in;
   meta_type                    s_meta_ff;
   logic                        o_valid_ff, o_valid_in;
   logic [NUM_CH-1:0][CH_W-1:0] o_mean_ff;
   meta_type                    o_meta_ff;
   logic                        adv_out;

   // Stage handshakes: each register moves when the next one is free or draining
   assign adv_out   = !o_valid_ff || rsp.ready;
   assign win_ready = !s_valid_ff || adv_out;

   assign s_valid_in = win_ready ? win_valid : s_valid_ff;
   assign o_valid_in = adv_out ? s_valid_ff : o_valid_ff;

   // Nine-pixel sum per channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s_sum_in[ch] = '0;
         for (int k = 0; k < WIN_N; k++) begin
            s_sum_in[ch] = s_sum_in[ch] + SUM_W'(win[k][ch*CH_W +: CH_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // Sum register
   always_ff @(posedge clock) begin
      if (win_ready && win_valid) begin
         s_sum_ff  <= s_sum_in;
         s_meta_ff <= win_meta;
      end
   end

   // Divide by nine into the output register
   always_ff @(posedge clock) begin
      if (adv_out && s_valid_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            o_mean_ff[ch] <= div9(s_sum_ff[ch]);
         end
         o_meta_ff <= s_meta_ff;
      end
   end

   assign rsp.valid      = o_valid_ff;
   assign rsp.mean0      = o_mean_ff[0];
   assign rsp.mean1      = o_mean_ff[1];
   assign rsp.mean2      = o_mean_ff[2];
   assign rsp.centre_row = o_meta_ff.row;
   assign rsp.centre_col = o_meta_ff.col;
   assign rsp.frame_end  = o_meta_ff.frame_end;

endmodule
